>>> hdl/sli_pkg.sv
// Package: sizes, codes and shared types of the sorted list store.
`default_nettype none
package sli_pkg;
    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int OP_W     = 2;
    localparam int ST_W     = 2;
    localparam int OCC_W    = 6;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic                    we;
        logic [IDX_W-1:0]        waddr;
        logic signed [VAL_W-1:0] wdata;
        logic                    re;
        logic [IDX_W-1:0]        raddr;
    } t_mem_req;

    typedef struct packed {
        logic                    vld;
        logic signed [VAL_W-1:0] entry_value;
        logic [ST_W-1:0]         status;
        logic                    last;
        logic [OCC_W-1:0]        occupancy;
    } t_res;
endpackage
`default_nettype wire

>>> hdl/sli_if.sv
// Interfaces: request and result channels of the sorted list store.
`default_nettype none
interface sli_in_if import sli_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         opcode;
    logic signed [VAL_W-1:0] value;
    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface sli_out_if import sli_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] entry_value;
    logic [ST_W-1:0]         status;
    logic                    last;
    logic [OCC_W-1:0]        occupancy;
    modport source (output valid, output entry_value, output status, output last,
                    output occupancy, input ready);
    modport sink   (input valid, input entry_value, input status, input last,
                    input occupancy, output ready);
endinterface
`default_nettype wire

>>> hdl/sli_ram.sv
// Generic single-port-write, registered-read RAM holding the sorted entries.
`default_nettype none
module sli_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

>>> hdl/sli_ctrl.sv
// Sequencer: scans, shifts and dumps the entries through the RAM.
`default_nettype none
module sli_ctrl import sli_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    sli_in_if.sink                       i_req,
    input  wire logic                    i_slot_free,
    input  wire logic signed [VAL_W-1:0] i_rdata,
    output      t_mem_req                o_mem,
    output      t_res                    o_push
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_INS    = 3'd1;
    localparam logic [2:0] S_PUT    = 3'd2;
    localparam logic [2:0] S_DFIND  = 3'd3;
    localparam logic [2:0] S_DSHIFT = 3'd4;
    localparam logic [2:0] S_DUMP   = 3'd5;
    localparam logic [2:0] S_RES    = 3'd6;

    logic [2:0]              r_state, n_state;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic signed [VAL_W-1:0] r_val, n_val;
    logic [ST_W-1:0]         r_st, n_st;
    logic                    w_last;
    logic [IDX_W-1:0]        w_top;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_cnt);
    assign w_top  = IDX_W'(r_cnt - CNT_W'(1));

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        n_val   = r_val;
        n_st    = r_st;
        o_mem   = '0;
        o_push  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_val = i_req.value;
                    n_st  = ST_OK;
                    case (i_req.opcode)
                        OP_INSERT: begin
                            if (r_cnt == CNT_W'(CAPACITY)) begin
                                n_st    = ST_FULL;
                                n_state = S_RES;
                            end else if (r_cnt == '0) begin
                                o_mem.we    = 1'b1;
                                o_mem.waddr = '0;
                                o_mem.wdata = i_req.value;
                                n_cnt       = CNT_W'(1);
                                n_state     = S_RES;
                            end else begin
                                o_mem.re    = 1'b1;
                                o_mem.raddr = w_top;
                                n_idx       = w_top;
                                n_state     = S_INS;
                            end
                        end
                        OP_DELETE: begin
                            if (r_cnt == '0) begin
                                n_st    = ST_NOTFOUND;
                                n_state = S_RES;
                            end else begin
                                o_mem.re    = 1'b1;
                                o_mem.raddr = '0;
                                n_idx       = '0;
                                n_state     = S_DFIND;
                            end
                        end
                        OP_DUMP: begin
                            if (r_cnt == '0) begin
                                n_st    = ST_EMPTY;
                                n_state = S_RES;
                            end else begin
                                o_mem.re    = 1'b1;
                                o_mem.raddr = '0;
                                n_idx       = '0;
                                n_state     = S_DUMP;
                            end
                        end
                        default: begin
                            n_state = S_RES;
                        end
                    endcase
                end
            end
            S_INS: begin
                if (r_val < i_rdata) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = IDX_W'(r_idx + 1'b1);
                    o_mem.wdata = i_rdata;
                    if (r_idx == '0) begin
                        n_state = S_PUT;
                    end else begin
                        o_mem.re    = 1'b1;
                        o_mem.raddr = IDX_W'(r_idx - 1'b1);
                        n_idx       = IDX_W'(r_idx - 1'b1);
                    end
                end else begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = IDX_W'(r_idx + 1'b1);
                    o_mem.wdata = r_val;
                    n_cnt       = CNT_W'(r_cnt + 1'b1);
                    n_state     = S_RES;
                end
            end
            S_PUT: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = '0;
                o_mem.wdata = r_val;
                n_cnt       = CNT_W'(r_cnt + 1'b1);
                n_state     = S_RES;
            end
            S_DFIND: begin
                if (i_rdata == r_val) begin
                    if (w_last) begin
                        n_cnt   = CNT_W'(r_cnt - 1'b1);
                        n_state = S_RES;
                    end else begin
                        o_mem.re    = 1'b1;
                        o_mem.raddr = IDX_W'(r_idx + 1'b1);
                        n_idx       = IDX_W'(r_idx + 1'b1);
                        n_state     = S_DSHIFT;
                    end
                end else if (w_last) begin
                    n_st    = ST_NOTFOUND;
                    n_state = S_RES;
                end else begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = IDX_W'(r_idx + 1'b1);
                    n_idx       = IDX_W'(r_idx + 1'b1);
                end
            end
            S_DSHIFT: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = IDX_W'(r_idx - 1'b1);
                o_mem.wdata = i_rdata;
                if (w_last) begin
                    n_cnt   = CNT_W'(r_cnt - 1'b1);
                    n_state = S_RES;
                end else begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = IDX_W'(r_idx + 1'b1);
                    n_idx       = IDX_W'(r_idx + 1'b1);
                end
            end
            S_DUMP: begin
                if (i_slot_free) begin
                    o_push.vld         = 1'b1;
                    o_push.entry_value = i_rdata;
                    o_push.status      = ST_OK;
                    o_push.last        = w_last;
                    o_push.occupancy   = OCC_W'(r_cnt);
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_mem.re    = 1'b1;
                        o_mem.raddr = IDX_W'(r_idx + 1'b1);
                        n_idx       = IDX_W'(r_idx + 1'b1);
                    end
                end
            end
            S_RES: begin
                if (i_slot_free) begin
                    o_push.vld         = 1'b1;
                    o_push.entry_value = '0;
                    o_push.status      = r_st;
                    o_push.last        = 1'b1;
                    o_push.occupancy   = OCC_W'(r_cnt);
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_idx <= n_idx;
        r_val <= n_val;
        r_st  <= n_st;
    end
endmodule
`default_nettype wire

>>> hdl/sorted_list_insert_delete.sv
// Top level: sorted list store with RAM, sequencer and output register.
//
//   channel  dir  payload                                  handshake
//   i_req    in   opcode, value                            valid / ready
//   o_res    out  entry_value, status, last, occupancy     valid / ready
//
// Insert: shifts each larger entry up by one from the top, then writes the value;
// an empty store takes it directly, a full one reports FULL. Delete: scans from
// the bottom for a match, then shifts the later entries down. Dump: one result per entry.
// Each step is at most one RAM read and one write, paced by the registered read.
// Reset empties the store at once; no clearing pass.
// A stalled output holds the result register; a dump pauses until it drains.
`default_nettype none
module sorted_list_insert_delete import sli_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sli_in_if.sink    i_req,
    sli_out_if.source o_res
);
    t_mem_req                w_mem;
    t_res                    w_push;
    logic signed [VAL_W-1:0] w_rdata;
    logic                    w_slot_free;

    logic                    r_vld;
    logic signed [VAL_W-1:0] r_entry;
    logic [ST_W-1:0]         r_st;
    logic                    r_last;
    logic [OCC_W-1:0]        r_occ;

    assign w_slot_free = !r_vld || o_res.ready;

    sli_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VAL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wdata),
        .i_re    (w_mem.re),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rdata)
    );

    sli_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_slot_free (w_slot_free),
        .i_rdata     (w_rdata),
        .o_mem       (w_mem),
        .o_push      (w_push)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_push.vld) begin
            r_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_vld <= 1'b0;
        end
        if (w_push.vld) begin
            r_entry <= w_push.entry_value;
            r_st    <= w_push.status;
            r_last  <= w_push.last;
            r_occ   <= w_push.occupancy;
        end
    end

    assign o_res.valid       = r_vld;
    assign o_res.entry_value = r_entry;
    assign o_res.status      = r_st;
    assign o_res.last        = r_last;
    assign o_res.occupancy   = r_occ;

`ifndef SYNTHESIS
    a_push_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.vld |-> w_slot_free)
        else $error("result pushed into an occupied output register");

    a_status_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.vld && w_push.status != ST_OK) |-> (w_push.last && w_push.entry_value == '0))
        else $error("status result without last or with nonzero entry");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while previous one still in work");

    a_no_mem_conflict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mem.we && w_mem.re) |-> (w_mem.waddr != w_mem.raddr))
        else $error("RAM read and write to the same entry in one cycle");
`endif
endmodule
`default_nettype wire

>>> dv/testbench.sv
// Testbench: directed and random request streams checked against a sorted list predictor.
module testbench;
    import sli_pkg::*;

    localparam logic [OP_W-1:0] OP_NOP = 2'd3;
    localparam int RAND_ITEMS  = 320;
    localparam int PHASE_LEN   = 50;
    localparam int MAX_GAP     = 13;
    localparam int HOLD_CYCLES = 160;
    localparam int HOLD_AFTER  = 45;
    localparam int TAIL_CYCLES = 80;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [OP_W-1:0]         op;
        logic signed [VAL_W-1:0] val;
        bit                      wait_idle;
    } t_request;

    typedef struct {
        logic signed [VAL_W-1:0] entry_value;
        logic [ST_W-1:0]         status;
        logic                    last;
        logic [OCC_W-1:0]        occupancy;
    } t_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sli_in_if  req_if ();
    sli_out_if res_if ();

    sorted_list_insert_delete uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    t_request                pending_reqs[$];
    t_result                 expected_results[$];
    logic signed [VAL_W-1:0] model_list[$];
    logic signed [VAL_W-1:0] live_values[$];   // values the stimulus believes are stored

    int total_reqs    = 0;
    int reqs_offered  = 0;
    int reqs_accepted = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int send_gap      = 0;
    int recv_gap      = 0;
    int hold_left     = 0;
    bit hold_used     = 1'b0;
    bit recv_hold     = 1'b0;
    bit req_fire      = 1'b0;
    bit res_fire      = 1'b0;

    always #2 i_clk = ~i_clk;

    function automatic void apply_list_op(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] val);
        int pos;
        logic [ST_W-1:0] st;
        st = ST_OK;
        case (op)
            OP_INSERT: begin
                if (model_list.size() >= CAPACITY) begin
                    st = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < model_list.size() && !(val < model_list[pos])) begin
                        pos++;
                    end
                    model_list.insert(pos, val);
                end
            end
            OP_DELETE: begin
                pos = 0;
                while (pos < model_list.size() && model_list[pos] != val) begin
                    pos++;
                end
                if (pos == model_list.size()) begin
                    st = ST_NOTFOUND;
                end else begin
                    model_list.delete(pos);
                end
            end
            OP_DUMP: begin
                if (model_list.size() == 0) begin
                    st = ST_EMPTY;
                end else begin
                    foreach (model_list[i]) begin
                        expected_results.push_back('{model_list[i], ST_OK,
                            i == model_list.size() - 1, OCC_W'(model_list.size())});
                    end
                    return;
                end
            end
            default: ;
        endcase
        expected_results.push_back('{'0, st, 1'b1, OCC_W'(model_list.size())});
    endfunction

    function automatic void push_request(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] val,
                                         bit wait_idle = 1'b0);
        pending_reqs.push_back('{op, val, wait_idle});
        total_reqs++;
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            case ($urandom_range(0, 3))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return '0;
                default: return '1;
            endcase
        end
        if (r < 4) begin
            return int'($urandom_range(0, 16)) - 8;
        end
        return $urandom();
    endfunction

    // phases: 0 and 2 fill, 1 mixed, 3 drain
    function automatic logic [OP_W-1:0] pick_op(int phase);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            return OP_NOP;
        end
        if (r < 11) begin
            return OP_DUMP;
        end
        case (phase)
            0, 2: return (r < 88) ? OP_INSERT : OP_DELETE;
            1: return (r < 55) ? OP_INSERT : OP_DELETE;
            default: return (r < 30) ? OP_INSERT : OP_DELETE;
        endcase
    endfunction

    function automatic void flag_error(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endfunction

    // request driver
    always @(negedge i_clk) begin
        t_request nxt;
        bit drive;
        drive = req_if.valid && !req_fire;
        if (i_rst_n && !drive) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_reqs.size() > 0 &&
                         !(pending_reqs[0].wait_idle && expected_results.size() > 0)) begin
                nxt = pending_reqs.pop_front();
                req_if.opcode <= nxt.op;
                req_if.value  <= nxt.val;
                drive = 1'b1;
                send_gap = ((reqs_offered / 60) % 3 == 2) ? 0 : $urandom_range(0, MAX_GAP);
                reqs_offered++;
            end
        end
        req_if.valid <= drive;
    end

    // long back-pressure stretch once HOLD_AFTER requests have been accepted
    always @(negedge i_clk) begin
        if (!hold_used && reqs_accepted >= HOLD_AFTER) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
        end
        recv_hold <= (hold_left > 0);
    end

    // result receiver
    always @(negedge i_clk) begin
        bit rdy;
        if (res_fire) begin
            recv_gap = ((results_seen / 70) % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
        end
        if (recv_gap > 0) begin
            recv_gap--;
            rdy = 1'b0;
        end else begin
            rdy = !recv_hold;
        end
        res_if.ready <= rdy && i_rst_n;
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge i_clk) begin
        t_result want;
        req_fire <= i_rst_n && req_if.valid && req_if.ready;
        res_fire <= i_rst_n && res_if.valid && res_if.ready;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            apply_list_op(req_if.opcode, req_if.value);
            reqs_accepted++;
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                flag_error($sformatf("result %0d unexpected: value %0d status %0d last %0b occ %0d",
                    results_seen, res_if.entry_value, res_if.status, res_if.last,
                    res_if.occupancy));
            end else begin
                want = expected_results.pop_front();
                if (res_if.entry_value !== want.entry_value || res_if.status !== want.status ||
                    res_if.last !== want.last || res_if.occupancy !== want.occupancy) begin
                    flag_error($sformatf(
                        "result %0d: got value %0d status %0d last %0b occ %0d, want %0d %0d %0b %0d",
                        results_seen, res_if.entry_value, res_if.status, res_if.last,
                        res_if.occupancy, want.entry_value, want.status, want.last,
                        want.occupancy));
                end
            end
        end
    end

    initial begin
        logic [OP_W-1:0]         op;
        logic signed [VAL_W-1:0] val;
        int                      k;

        req_if.valid  = 1'b0;
        req_if.opcode = OP_INSERT;
        req_if.value  = '0;
        res_if.ready  = 1'b0;

        // directed: empty list, extremes, duplicates, hits and misses, unused opcode
        push_request(OP_DUMP,   '0);
        push_request(OP_DELETE, 5);
        push_request(OP_NOP,    '0);
        push_request(OP_INSERT, 32'sh7FFF_FFFF);
        push_request(OP_INSERT, 32'sh8000_0000);
        push_request(OP_INSERT, 0);
        push_request(OP_INSERT, -1);
        push_request(OP_INSERT, 0);
        push_request(OP_INSERT, 1);
        push_request(OP_DUMP,   '0);
        push_request(OP_DELETE, 0);
        push_request(OP_DELETE, 32'sh8000_0000);
        push_request(OP_DELETE, 42);
        push_request(OP_DELETE, 32'sh7FFF_FFFF);
        push_request(OP_NOP,    '1);
        push_request(OP_DUMP,   '0);
        push_request(OP_DELETE, -1);
        push_request(OP_DELETE, 0);
        push_request(OP_DELETE, 1);
        push_request(OP_DUMP,   '1);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            op = pick_op((n / PHASE_LEN) % 4);
            if (op == OP_DELETE && live_values.size() > 0 && $urandom_range(0, 3) != 0) begin
                k = $urandom_range(0, live_values.size() - 1);
                val = live_values[k];
                live_values.delete(k);
            end else begin
                val = pick_value();
                if (op == OP_INSERT && live_values.size() < CAPACITY) begin
                    live_values.push_back(val);
                end
            end
            push_request(op, val, n % PHASE_LEN == 0);
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (reqs_accepted < total_reqs || expected_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #(4 * 1_000_000);
        $display("Verification failed");
        $finish;
    end
endmodule

>>> files.f
hdl/sli_pkg.sv
hdl/sli_if.sv
hdl/sli_ram.sv
hdl/sli_ctrl.sv
hdl/sorted_list_insert_delete.sv
dv/testbench.sv
